@@ rtl/record_ring_buffer_framer_defines.svh @@
// ----------------------------------------------------------------------------
// Record ring buffer framer: assertion macros
// Wraps concurrent assertions so that synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef RECORD_RING_BUFFER_FRAMER_DEFINES_SVH
`define RECORD_RING_BUFFER_FRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge out of reset
`define RRBF_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("rrbf: invariant violated");

// Same-cycle implication
`define RRBF_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("rrbf: implication violated");

// Next-cycle implication
`define RRBF_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("rrbf: next-cycle implication violated");

`else

`define RRBF_ASSERT_ALWAYS(lbl, cond)
`define RRBF_ASSERT_IMP(lbl, pre, post)
`define RRBF_ASSERT_NXT(lbl, pre, post)

`endif

`endif

@@ rtl/rrbf_pkg.sv @@
// ----------------------------------------------------------------------------
// rrbf_pkg
// Shared types and constants of the record ring buffer framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrbf_pkg;

    // Field and register widths
    localparam int FILL_W     = 13;
    localparam int RB_W       = 13;
    localparam int HI_W       = 16;
    localparam int RC_W       = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_CHUNK    = 2'd2;

    // Register reset values
    localparam logic [RB_W-1:0] RB_RESET = 13'd0;
    localparam logic [HI_W-1:0] HI_RESET = 16'd256;
    localparam logic [RC_W-1:0] RC_RESET = 7'd64;

    // Sync word, stored low byte first
    localparam logic [31:0] SYNC_WORD  = 32'h5555_AAAA;
    localparam int          SYNC_BYTES = 4;

    // Input action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_REFUSE = 2'd2;

    // Classified command handed from front to back
    typedef enum logic {
        OP_WRITE,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    // Request payload
    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } t_in;

    // Result payload
    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        read_byte;
        logic              last;
        logic              dropped;
        logic [FILL_W-1:0] fill_level;
    } t_out;

endpackage

@@ rtl/rrbf_ram.sv @@
// ----------------------------------------------------------------------------
// rrbf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/rrbf_front.sv @@
// ----------------------------------------------------------------------------
// rrbf_front
// Accepts requests, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrbf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  rrbf_pkg::t_in i_in,
    output logic          busy,
    output logic          o_cmd_valid,
    output rrbf_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);

    import rrbf_pkg::*;

    // Two-entry command queue
    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;
    t_cmd       cmd_in;

    // Classify the request
    always_comb begin
        cmd_in.op   = (i_in.action == ACT_READ) ? OP_READ : OP_WRITE;
        cmd_in.data = i_in.data_byte;
    end

    assign busy        = (r_count == 2'd2);
    assign push        = start && !busy;
    assign o_cmd_valid = (r_count != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    // Queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

@@ rtl/rrbf_back.sv @@
// ----------------------------------------------------------------------------
// rrbf_back
// Engine: record framing, drop decision, sync insertion and chunk reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "record_ring_buffer_framer_defines.svh"

module rrbf_back #(
    parameter int BUFFER_BYTES = 4096,
    parameter int MAX_CHUNK    = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rrbf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rrbf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_cmd_valid,
    input  rrbf_pkg::t_cmd                     i_cmd,
    output logic                               o_cmd_pop,
    output logic                               o_result_valid,
    output rrbf_pkg::t_out                     o_result
);

    import rrbf_pkg::*;

    localparam int AW  = $clog2(BUFFER_BYTES);
    localparam int CW  = $clog2(BUFFER_BYTES + 1);
    localparam int SW  = ((CW > FILL_W) ? CW : FILL_W) + 1;
    localparam int CHW = $clog2(MAX_CHUNK + 1);

    localparam logic [AW-1:0] PTR_LAST = AW'(BUFFER_BYTES - 1);
    localparam logic [SW-1:0] BUF_SZ   = SW'(BUFFER_BYTES);
    localparam logic [SW-1:0] SYNC_SZ  = SW'(SYNC_BYTES);
    localparam logic [1:0]    SYNC_END = 2'(SYNC_BYTES - 1);
    localparam logic [RC_W-1:0] CHUNK_MAX = RC_W'(MAX_CHUNK);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SYNC,
        S_READ
    } t_state;

    t_state          r_state,   n_state;
    logic [RB_W-1:0] r_rb,      n_rb;
    logic [HI_W-1:0] r_hi,      n_hi;
    logic [RC_W-1:0] r_rc,      n_rc;
    logic [AW-1:0]   r_wp,      n_wp;
    logic [AW-1:0]   r_rp,      n_rp;
    logic [CW-1:0]   r_held,    n_held;
    logic [RB_W-1:0] r_bir,     n_bir;
    logic [HI_W-1:0] r_rsh,     n_rsh;
    logic            r_dropping, n_dropping;
    logic [1:0]      r_sidx,    n_sidx;
    logic [CHW-1:0]  r_chunk,   n_chunk;
    logic [CHW-1:0]  r_cnt,     n_cnt;
    logic            r_rd_vld,  n_rd_vld;
    logic            r_rd_last, n_rd_last;
    logic            r_out_valid, n_out_valid;
    t_out            r_out,     n_out;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic [7:0]      ram_rdata;

    // Write-path decision terms
    logic [SW-1:0]   held_ext;
    logic            fit_fail;
    logic            drop_w;
    logic [CW-1:0]   held_w;
    logic [RB_W-1:0] bir_inc;
    logic            rec_end;
    logic [HI_W-1:0] rsh_inc;
    logic            head_due;
    logic            sync_ok;
    logic [AW-1:0]   wp_inc;
    logic [AW-1:0]   rp_inc;

    // Read-path terms
    logic [RC_W-1:0] chunk_eff;
    logic            refuse;
    logic            rd_end;

    function automatic logic [FILL_W-1:0] to_fill(input logic [CW-1:0] h);
        logic [SW-1:0] ext;
        ext = SW'(h);
        return ext[FILL_W-1:0];
    endfunction

    rrbf_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    // Pointer wrap
    assign wp_inc = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
    assign rp_inc = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;

    // Record framing and drop decision for a write
    assign held_ext = SW'(r_held);
    assign fit_fail = (held_ext + SW'(r_rb) + SYNC_SZ) >= BUF_SZ;
    assign drop_w   = ((r_bir == '0) ? fit_fail : r_dropping) || (held_ext >= BUF_SZ);
    assign held_w   = drop_w ? r_held : r_held + 1'b1;
    assign bir_inc  = r_bir + 1'b1;
    assign rec_end  = (bir_inc >= r_rb);
    assign rsh_inc  = r_rsh + 1'b1;
    assign head_due = rec_end && !drop_w && (rsh_inc >= r_hi);
    assign sync_ok  = (SW'(held_w) + SYNC_SZ) <= BUF_SZ;

    // Chunk size and grant
    assign chunk_eff = (r_rc > CHUNK_MAX) ? CHUNK_MAX : r_rc;
    assign refuse    = (chunk_eff == '0) || (held_ext < SW'(chunk_eff));
    assign rd_end    = (CHW'(r_cnt + 1'b1) == r_chunk);

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_rb        = r_rb;
        n_hi        = r_hi;
        n_rc        = r_rc;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_held      = r_held;
        n_bir       = r_bir;
        n_rsh       = r_rsh;
        n_dropping  = r_dropping;
        n_sidx      = r_sidx;
        n_chunk     = r_chunk;
        n_cnt       = r_cnt;
        n_rd_vld    = 1'b0;
        n_rd_last   = r_rd_last;
        n_out_valid = 1'b0;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_wp;
        ram_wdata   = i_cmd.data;
        o_cmd_pop   = 1'b0;

        // Configuration writes
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RECORD_BYTES:  n_rb = i_cfg_data[RB_W-1:0];
                CFG_HEAD_INTERVAL: n_hi = i_cfg_data[HI_W-1:0];
                CFG_READ_CHUNK:    n_rc = i_cfg_data[RC_W-1:0];
                default:           ;
            endcase
        end

        // Read byte coming back from the store
        if (r_rd_vld) begin
            n_out_valid      = 1'b1;
            n_out.kind       = KIND_BYTE;
            n_out.read_byte  = ram_rdata;
            n_out.last       = r_rd_last;
            n_out.dropped    = 1'b0;
            n_out.fill_level = to_fill(r_held);
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !r_rd_vld) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == OP_WRITE) begin
                        n_out.kind      = KIND_ACK;
                        n_out.read_byte = 8'd0;
                        n_out.last      = 1'b1;
                        if (r_rb == '0) begin
                            // zero record size: drop, nothing counted
                            n_out_valid      = 1'b1;
                            n_out.dropped    = 1'b1;
                            n_out.fill_level = to_fill(r_held);
                        end else begin
                            ram_we = !drop_w;
                            if (!drop_w) begin
                                n_wp = wp_inc;
                            end
                            n_held = held_w;
                            if (rec_end) begin
                                n_bir      = '0;
                                n_dropping = 1'b0;
                                if (!drop_w) begin
                                    n_rsh = head_due ? '0 : rsh_inc;
                                end
                            end else begin
                                n_bir      = bir_inc;
                                n_dropping = drop_w;
                            end
                            n_out.dropped    = drop_w;
                            n_out.fill_level = to_fill(held_w);
                            if (head_due && sync_ok) begin
                                n_sidx  = 2'd0;
                                n_state = S_SYNC;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                    end else begin
                        if (refuse) begin
                            n_out_valid      = 1'b1;
                            n_out.kind       = KIND_REFUSE;
                            n_out.read_byte  = 8'd0;
                            n_out.last       = 1'b1;
                            n_out.dropped    = 1'b0;
                            n_out.fill_level = to_fill(r_held);
                        end else begin
                            n_held  = r_held - CW'(chunk_eff);
                            n_chunk = CHW'(chunk_eff);
                            n_cnt   = '0;
                            n_state = S_READ;
                        end
                    end
                end
            end

            // Append sync word, one byte per cycle
            S_SYNC: begin
                ram_we    = 1'b1;
                ram_wdata = SYNC_WORD[{r_sidx, 3'b000} +: 8];
                n_wp      = wp_inc;
                n_held    = r_held + 1'b1;
                n_sidx    = r_sidx + 2'd1;
                if (r_sidx == SYNC_END) begin
                    n_out_valid      = 1'b1;
                    n_out.fill_level = to_fill(n_held);
                    n_state          = S_IDLE;
                end
            end

            // Issue chunk reads, one address per cycle
            S_READ: begin
                n_rp      = rp_inc;
                n_cnt     = r_cnt + 1'b1;
                n_rd_vld  = 1'b1;
                n_rd_last = rd_end;
                if (rd_end) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rb        <= RB_RESET;
            r_hi        <= HI_RESET;
            r_rc        <= RC_RESET;
            r_wp        <= '0;
            r_rp        <= '0;
            r_held      <= '0;
            r_bir       <= '0;
            r_rsh       <= '0;
            r_dropping  <= 1'b0;
            r_sidx      <= 2'd0;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rb        <= n_rb;
            r_hi        <= n_hi;
            r_rc        <= n_rc;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_held      <= n_held;
            r_bir       <= n_bir;
            r_rsh       <= n_rsh;
            r_dropping  <= n_dropping;
            r_sidx      <= n_sidx;
            r_cnt       <= n_cnt;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
        r_chunk   <= n_chunk;
        r_rd_last <= n_rd_last;
        r_out     <= n_out;
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // Checks; the read pointer trails the count while a chunk is issued
    `RRBF_ASSERT_ALWAYS(a_held_bound, SW'(r_held) <= BUF_SZ)
    `RRBF_ASSERT_IMP(a_empty_ptrs, (r_held == '0) && (r_state != S_READ), r_wp == r_rp)
    `RRBF_ASSERT_IMP(a_full_ptrs, SW'(r_held) == BUF_SZ, r_wp == r_rp)
    `RRBF_ASSERT_NXT(a_read_held_stable, r_state == S_READ, $stable(r_held))

endmodule

@@ rtl/record_ring_buffer_framer.sv @@
// ----------------------------------------------------------------------------
// record_ring_buffer_framer
// Circular byte store for waveform records with sync word insertion.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start / i_in while busy is low; action 0 writes one
//   record byte, action 1 asks for one chunk of read_chunk bytes, capped at MAX_CHUNK.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the
//   user must do so only while no request is outstanding (not enforced).
//   Results leave on o_result, marked by o_result_valid for one cycle each.
//   The receiver cannot stall; every result must be taken when shown.
// Timing:
//   A two-entry queue holds requests ahead of the engine; busy is high
//   while it is full. A write result passes from the queue through the
//   engine to its output register; when a sync word is appended, the sync
//   bytes are written first and the result follows the last of them. A
//   refused read returns a single refusal result. A granted read streams
//   its bytes one per cycle from the store's registered read port and
//   holds the engine until its last byte has been read from the store.
// Reset:
//   Synchronous reset empties the store pointers and counters and restores
//   the register defaults; store contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module record_ring_buffer_framer #(
    parameter int BUFFER_BYTES = 4096,
    parameter int MAX_CHUNK    = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  rrbf_pkg::t_in                   i_in,
    output logic                            busy,
    output logic                            o_result_valid,
    output rrbf_pkg::t_out                  o_result,
    input  logic                            i_cfg_we,
    input  logic [rrbf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rrbf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import rrbf_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    // Request intake and queue
    rrbf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_in        (i_in),
        .busy        (busy),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Framing engine and store
    rrbf_back #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_CHUNK    (MAX_CHUNK)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_cmd_pop      (cmd_pop),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

@@ sim/tb_record_ring_buffer_framer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_record_ring_buffer_framer
// Self-checking bench for the record ring buffer framer. A scoreboard keeps
// its own copy of the ring, pointers, record counters and registers. It
// predicts every acknowledge, read byte and refusal, and checks each result
// strobe against the oldest prediction. Stimulus runs in two parts:
//   - directed requests for the corner cases
//   - random segments under varied register settings, most with random gaps
// ----------------------------------------------------------------------------

module tb_record_ring_buffer_framer;
    import rrbf_pkg::*;

    localparam int BUFFER_BYTES  = 4096;
    localparam int MAX_CHUNK     = 64;
    // Slowest run: about 300 requests, each with the longest gap pick_gap gives
    // plus a read burst of MAX_CHUNK bytes, with wide margin on top.
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_ITEMS = 40;

    // ------------------------------------------------------------------------
    // Scoreboard: ring prediction and result checking
    // ------------------------------------------------------------------------
    class ring_model_sb;
        t_out        owed_results[$];
        logic [7:0]  ring_mem[BUFFER_BYTES];
        int unsigned wr_ptr;
        int unsigned rd_ptr;
        int unsigned held;
        int unsigned rec_pos;
        int unsigned recs_since_sync;
        bit          drop_rec;
        int unsigned rec_bytes;
        int unsigned sync_every;
        int unsigned chunk_cfg;
        int unsigned errors;
        int unsigned results_seen;
        int unsigned requests;
        int unsigned bytes_kept;
        int unsigned bytes_dropped;
        int unsigned chunks_sent;
        int unsigned reads_refused;
        int unsigned syncs_put;
        int unsigned syncs_skipped;

        function new();
            wr_ptr          = 0;
            rd_ptr          = 0;
            held            = 0;
            rec_pos         = 0;
            recs_since_sync = 0;
            drop_rec        = 1'b0;
            rec_bytes       = RB_RESET;
            sync_every      = HI_RESET;
            chunk_cfg       = RC_RESET;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_RECORD_BYTES:  rec_bytes  = value[RB_W-1:0];
                CFG_HEAD_INTERVAL: sync_every = value[HI_W-1:0];
                CFG_READ_CHUNK:    chunk_cfg  = value[RC_W-1:0];
                default: ;
            endcase
        endfunction

        function void put_byte(logic [7:0] b);
            ring_mem[wr_ptr] = b;
            wr_ptr = (wr_ptr + 1) % BUFFER_BYTES;
            held++;
        endfunction

        // Queue one predicted result; fill level is taken after the update
        function void owe(logic [1:0] kind, logic [7:0] data, logic last, logic drop);
            t_out r;
            r.kind       = kind;
            r.read_byte  = data;
            r.last       = last;
            r.dropped    = drop;
            r.fill_level = held[FILL_W-1:0];
            owed_results.push_back(r);
        endfunction

        // Advance the ring by one accepted request and queue its results
        function void accept_request(t_in req);
            int unsigned n;
            int unsigned k;
            bit          rec_dropped;
            logic [7:0]  chunk_bytes[MAX_CHUNK];
            requests++;
            if (req.action == ACT_WRITE) begin
                // zero record size: nothing is stored or counted
                if (rec_bytes == 0) begin
                    bytes_dropped++;
                    owe(KIND_ACK, 8'h00, 1'b1, 1'b1);
                    return;
                end
                // fit test for record plus sync word at the first byte
                if (rec_pos == 0)
                    drop_rec = (held + rec_bytes + SYNC_BYTES >= BUFFER_BYTES);
                // store full: the rest of the record goes too
                if (!drop_rec && held >= BUFFER_BYTES)
                    drop_rec = 1'b1;
                rec_dropped = drop_rec;
                if (rec_dropped) begin
                    bytes_dropped++;
                end else begin
                    put_byte(req.data_byte);
                    bytes_kept++;
                end
                rec_pos = (rec_pos + 1) & 32'h1FFF;
                // record end; also catches a size lowered mid-record
                if (rec_pos >= rec_bytes) begin
                    rec_pos = 0;
                    if (!drop_rec) begin
                        recs_since_sync = (recs_since_sync + 1) & 32'hFFFF;
                        if (recs_since_sync >= sync_every) begin
                            if (held + SYNC_BYTES <= BUFFER_BYTES) begin
                                for (k = 0; k < SYNC_BYTES; k++)
                                    put_byte(SYNC_WORD[8*k +: 8]);
                                syncs_put++;
                            end else begin
                                syncs_skipped++;
                            end
                            recs_since_sync = 0;
                        end
                    end
                    drop_rec = 1'b0;
                end
                owe(KIND_ACK, 8'h00, 1'b1, rec_dropped);
            end else begin
                n = (chunk_cfg > MAX_CHUNK) ? MAX_CHUNK : chunk_cfg;
                if (n == 0 || held < n) begin
                    reads_refused++;
                    owe(KIND_REFUSE, 8'h00, 1'b1, 1'b0);
                    return;
                end
                for (k = 0; k < n; k++) begin
                    chunk_bytes[k] = ring_mem[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % BUFFER_BYTES;
                end
                held -= n;
                for (k = 0; k < n; k++)
                    owe(KIND_BYTE, chunk_bytes[k], (k + 1 == n), 1'b0);
                chunks_sent++;
            end
        endfunction

        task report(string what);
            $display("ERROR @%0t: %s", $time, what);
            errors++;
        endtask

        task check_result(t_out got);
            t_out want;
            results_seen++;
            if (owed_results.size() == 0) begin
                report($sformatf("unexpected result kind=%0d byte=%02h fill=%0d",
                                 got.kind, got.read_byte, got.fill_level));
            end else begin
                want = owed_results.pop_front();
                if (got.kind !== want.kind || got.read_byte !== want.read_byte ||
                    got.last !== want.last || got.dropped !== want.dropped ||
                    got.fill_level !== want.fill_level)
                    report($sformatf({"result %0d: got kind=%0d byte=%02h last=%0b ",
                                      "drop=%0b fill=%0d, exp kind=%0d byte=%02h ",
                                      "last=%0b drop=%0b fill=%0d"},
                                     results_seen, got.kind, got.read_byte, got.last,
                                     got.dropped, got.fill_level, want.kind,
                                     want.read_byte, want.last, want.dropped,
                                     want.fill_level));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    t_in                   i_in       = '0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  busy;
    logic                  o_result_valid;
    t_out                  o_result;

    ring_model_sb model = new();
    int unsigned  cycle_count = 0;
    bit           gaps_on = 1'b1;

    always #5 i_clk = ~i_clk;

    record_ring_buffer_framer #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .MAX_CHUNK   (MAX_CHUNK)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_in          (i_in),
        .busy          (busy),
        .o_result_valid(o_result_valid),
        .o_result      (o_result),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // Result strobes are checked on the edge that ends them
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1)
            model.check_result(o_result);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, model.owed_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic hold_off(int unsigned n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Present one request and hold it until busy lets it in
    task automatic send_request(logic action, logic [7:0] data);
        t_in req;
        req.action    = action;
        req.data_byte = data;
        start <= 1'b1;
        i_in  <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
        model.accept_request(req);
        hold_off(pick_gap());
    endtask

    task automatic write_bytes(int unsigned n);
        repeat (n) send_request(ACT_WRITE, 8'($urandom_range(0, 255)));
    endtask

    // Wait until every owed result is in and the engine has gone quiet
    task automatic settle();
        start <= 1'b0;
        while (model.owed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        model.write_reg(idx, value[CFG_DATA_W-1:0]);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned seg;
        int unsigned budget;
        int unsigned burst;
        int unsigned r;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero record size after reset: bytes are dropped
        send_request(ACT_WRITE, 8'h00);
        send_request(ACT_WRITE, 8'hFF);
        // read from an empty store
        send_request(ACT_READ, 8'h00);
        // zero read chunk
        set_reg(CFG_READ_CHUNK, 0);
        send_request(ACT_READ, 8'hFF);
        // zero head interval: sync word after every record
        set_reg(CFG_RECORD_BYTES, 4);
        set_reg(CFG_HEAD_INTERVAL, 0);
        send_request(ACT_WRITE, 8'h00);
        send_request(ACT_WRITE, 8'hFF);
        send_request(ACT_WRITE, 8'h5A);
        send_request(ACT_WRITE, 8'hA5);
        // oversized chunk clamps to the maximum: too little held
        set_reg(CFG_READ_CHUNK, 127);
        send_request(ACT_READ, 8'h00);
        set_reg(CFG_READ_CHUNK, 8);
        send_request(ACT_READ, 8'h00);
        // record size lowered mid-record ends it on the next byte
        set_reg(CFG_HEAD_INTERVAL, 1);
        set_reg(CFG_RECORD_BYTES, 3);
        write_bytes(2);
        set_reg(CFG_RECORD_BYTES, 1);
        write_bytes(1);
        set_reg(CFG_READ_CHUNK, 7);
        send_request(ACT_READ, 8'h00);
        // records that can never fit
        set_reg(CFG_HEAD_INTERVAL, 65535);
        set_reg(CFG_RECORD_BYTES, 4096);
        write_bytes(1);
        set_reg(CFG_RECORD_BYTES, 8191);
        write_bytes(1);

        // Random segments, each under its own register setting
        for (seg = 0; seg < SEGMENTS; seg++) begin
            r = $urandom_range(0, 9);
            if (r < 6)
                set_reg(CFG_RECORD_BYTES, $urandom_range(1, 8));
            else if (r < 8)
                set_reg(CFG_RECORD_BYTES, $urandom_range(9, 64));
            else if (r < 9)
                set_reg(CFG_RECORD_BYTES, $urandom_range(100, 600));
            else
                set_reg(CFG_RECORD_BYTES, ($urandom_range(0, 1) != 0) ? 4096 : 0);
            r = $urandom_range(0, 9);
            if (r < 7)
                set_reg(CFG_HEAD_INTERVAL, $urandom_range(0, 3));
            else if (r < 8)
                set_reg(CFG_HEAD_INTERVAL, 65535);
            else
                set_reg(CFG_HEAD_INTERVAL, $urandom_range(1, 65535));
            r = $urandom_range(0, 9);
            if (r < 6)
                set_reg(CFG_READ_CHUNK, $urandom_range(1, 16));
            else if (r < 7)
                set_reg(CFG_READ_CHUNK, 64);
            else if (r < 8)
                set_reg(CFG_READ_CHUNK, 127);
            else if (r < 9)
                set_reg(CFG_READ_CHUNK, 0);
            else
                set_reg(CFG_READ_CHUNK, $urandom_range(17, 127));
            gaps_on = ($urandom_range(0, 3) != 0);

            budget = 0;
            while (budget < SEGMENT_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    // a whole record of random bytes, or a short run when the size is 0 or above 64
                    burst = (model.rec_bytes == 0 || model.rec_bytes > 64) ?
                            $urandom_range(1, 8) : model.rec_bytes;
                    write_bytes(burst);
                    budget += burst;
                end else if (r < 78) begin
                    // stray byte that breaks record alignment
                    write_bytes(1);
                    budget++;
                end else begin
                    send_request(ACT_READ, 8'($urandom_range(0, 255)));
                    budget++;
                end
            end
        end
        gaps_on = 1'b1;

        settle();
        repeat (20) @(posedge i_clk);

        $display("covered %0d requests: %0d bytes stored, %0d dropped,",
                 model.requests, model.bytes_kept, model.bytes_dropped);
        $display("  %0d chunks read, %0d reads refused, sync words %0d in, %0d skipped",
                 model.chunks_sent, model.reads_refused, model.syncs_put,
                 model.syncs_skipped);
        $display("%0d results checked, %0d mismatches", model.results_seen, model.errors);
        if (model.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
